### rtl/core/mjd2cal_pkg.sv
`timescale 1ns / 1ps

package mjd2cal_pkg;

   // Bounds of the supported span, 0001-01-01 through 9999-12-31.
   localparam logic signed [22:0] MJD_LOW  = -23'sd678577;
   localparam logic signed [22:0] MJD_HIGH = 23'sd2973483;
   localparam logic [26:0]        MS_DAY_MAX = 27'd86399999;

   // Julian day number at noon is the MJD day plus this offset.
   localparam logic [22:0] JDN_OFFSET = 23'd2400001;
   // First Julian day number of the Gregorian calendar.
   localparam logic [22:0] REFORM_JDN = 23'd2299161;

   localparam logic [24:0] ALPHA_BIAS  = 25'd7468865;
   localparam logic [22:0] B_OFFSET    = 23'd1524;
   localparam logic [26:0] C_BIAS      = 27'd2442;
   localparam logic [24:0] DAYS_PER_4Y = 25'd1461;
   localparam logic [22:0] MONTH_SCALE = 23'd10000;

   localparam logic [3:0]  MONTH_WRAP       = 4'd14;
   localparam logic [3:0]  MONTH_FEBRUARY   = 4'd2;
   localparam logic [13:0] YEAR_OFF_MARCH   = 14'd4716;
   localparam logic [13:0] YEAR_OFF_JANUARY = 14'd4715;

   // Divisors handed to the constant dividers.
   localparam int DAYS_PER_400Y = 146097;
   localparam int C_DIVISOR     = 7305;
   localparam int MONTH_DIVISOR = 306001;
   localparam int MS_PER_HOUR   = 3600000;
   localparam int MS_PER_MINUTE = 60000;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] ms_of_minute;
   } tod_type;

   // floor(30.6001 * e): days before the start of month term e.
   function automatic logic [8:0] month_start(input logic [3:0] e);
      logic [8:0] res;
      case (e)
         4'd1:    res = 9'd30;
         4'd2:    res = 9'd61;
         4'd3:    res = 9'd91;
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd183;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd244;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd336;
         4'd12:   res = 9'd367;
         4'd13:   res = 9'd397;
         4'd14:   res = 9'd428;
         4'd15:   res = 9'd459;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

endpackage

### rtl/core/mjd2cal_slice.sv
`timescale 1ns / 1ps

module mjd2cal_slice #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   logic         valid_ff;
   logic         valid_in;
   logic [W-1:0] data_ff;

   // A stage takes a new beat when it is empty or its beat moves on, so bubbles close up.
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/core/mjd2cal_cdiv.sv
`timescale 1ns / 1ps

// Three-stage divider by a constant: reciprocal multiply, remainder, one correction step.
module mjd2cal_cdiv #(
   parameter int  NW = 27,
   parameter int  D  = 3,
   parameter int  QW = 4,
   parameter int  SW = 1,
   localparam int RW = $clog2(D)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [NW-1:0] num,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [QW-1:0] quo,
   output logic [RW-1:0] rem,
   output logic [SW-1:0] out_side
);

   localparam longint unsigned M = (64'd1 << NW) / D;
   localparam int MW = $clog2(M + 1);
   localparam int PW = NW + MW;
   localparam int W1 = SW + NW + PW;
   localparam int W2 = SW + MW + RW + 1;
   localparam int W3 = SW + QW + RW;
   localparam logic [PW-1:0] MP = PW'(M);
   localparam logic [NW-1:0] DN = NW'(D);
   localparam logic [RW:0]   DR = (RW + 1)'(D);

   logic [PW-1:0] prod;
   logic          m1_valid;
   logic          m1_ready;
   logic [W1-1:0] m1_q;
   logic [SW-1:0] m1_side;
   logic [NW-1:0] m1_num;
   logic [PW-1:0] m1_prod;
   logic [MW-1:0] q0;
   logic [NW-1:0] qd;
   logic [NW-1:0] r0_full;
   logic          m2_valid;
   logic          m2_ready;
   logic [W2-1:0] m2_q;
   logic [SW-1:0] m2_side;
   logic [MW-1:0] m2_q0;
   logic [RW:0]   m2_r0;
   logic          fix;
   logic [MW:0]   q1;
   logic [RW:0]   r1;
   logic [W3-1:0] m3_q;

   // The estimate floor(num * M / 2^NW) is the true quotient or one below it.
   assign prod = PW'(num) * MP;

   mjd2cal_slice #(.W(W1)) u_m1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_ready  (in_ready),
      .in_data   ({in_side, num, prod}),
      .out_valid (m1_valid),
      .out_ready (m1_ready),
      .out_data  (m1_q)
   );

   assign m1_side = m1_q[W1-1 -: SW];
   assign m1_num  = m1_q[PW +: NW];
   assign m1_prod = m1_q[PW-1:0];
   assign q0      = m1_prod[PW-1:NW];
   assign qd      = NW'(q0) * DN;
   assign r0_full = m1_num - qd;

   mjd2cal_slice #(.W(W2)) u_m2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m1_valid),
      .in_ready  (m1_ready),
      .in_data   ({m1_side, q0, r0_full[RW:0]}),
      .out_valid (m2_valid),
      .out_ready (m2_ready),
      .out_data  (m2_q)
   );

   assign m2_side = m2_q[W2-1 -: SW];
   assign m2_q0   = m2_q[RW+1 +: MW];
   assign m2_r0   = m2_q[RW:0];

   always_comb begin
      fix = (m2_r0 >= DR);
      q1  = (MW + 1)'(m2_q0) + (MW + 1)'(fix);
      r1  = fix ? (m2_r0 - DR) : m2_r0;
   end

   mjd2cal_slice #(.W(W3)) u_m3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m2_valid),
      .in_ready  (m2_ready),
      .in_data   ({m2_side, QW'(q1), r1[RW-1:0]}),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .out_data  (m3_q)
   );

   assign out_side = m3_q[W3-1 -: SW];
   assign quo      = m3_q[RW +: QW];
   assign rem      = m3_q[RW-1:0];

`ifndef SYNTH
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ({1'b0, rem} < DR))
      else $error("divider remainder not below divisor");

   a_one_correction: assert property (@(posedge clock) disable iff (reset)
      (m2_valid && (m2_r0 >= DR)) |-> ((m2_r0 - DR) < DR))
      else $error("quotient estimate off by more than one");
`endif

endmodule

### rtl/core/mjd_to_calendar_date_unit.sv
`timescale 1ns / 1ps

// Modified Julian Date to calendar date and time of day.
// Input channel req_: req_mjd_day (signed days) and req_ms_of_day (ms since midnight),
// taken when req_valid is high and req_stall is low. Out-of-range days clamp to
// 0001-01-01 .. 9999-12-31 and milliseconds clamp to the last millisecond of the day.
// Result channel rsp_: year, month, day, hour, minute and ms within the minute, one
// beat for every input beat, in order, taken when rsp_valid is high and rsp_stall low.
// Days before 1582-10-15 come out in the Julian calendar, later days in the Gregorian.
// Throughput is one beat per cycle while the receiver does not stall the result channel;
// the path is a chain of registered stages, five of them three-stage constant dividers.
// When the receiver stalls, the beats in flight close up behind the output register,
// and req_stall rises only once every stage holds a beat. A held result stays stable.
// Reset empties the pipeline; there is no other state and nothing to configure.
module mjd_to_calendar_date_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [22:0] req_mjd_day,
   input  logic [26:0]        req_ms_of_day,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [13:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [15:0]        rsp_ms_of_minute
);

   logic signed [22:0]   mjd_c;
   logic [26:0]          ms_c;
   logic [22:0]          z0;
   logic                 in_ready;

   logic                 s0_valid, s0_ready;
   logic [49:0]          s0_q;
   logic                 t1_valid, t1_ready;
   logic [4:0]           t1_quo;
   logic [21:0]          t1_rem;
   logic [22:0]          t1_side;
   logic                 t2_valid, t2_ready;
   logic [5:0]           t2_quo;
   logic [15:0]          t2_rem;
   logic [27:0]          t2_side;
   logic [22:0]          t2_z;
   mjd2cal_pkg::tod_type tod;
   logic                 greg;
   logic [23:0]          n_alpha;

   logic                 s1_valid, s1_ready;
   logic [74:0]          s1_q;
   logic                 a_valid, a_ready;
   logic [6:0]           a_quo;
   logic [50:0]          a_side;
   logic [7:0]           a_adj;
   logic [22:0]          b2;

   logic                 s2_valid, s2_ready;
   logic [49:0]          s2_q;
   logic [26:0]          n_c;
   logic                 s3_valid, s3_ready;
   logic [76:0]          s3_q;
   logic                 c_valid, c_ready;
   logic [13:0]          c_quo;
   logic [49:0]          c_side;
   logic [24:0]          d_prod;
   logic [8:0]           bd4;

   logic                 s4_valid, s4_ready;
   logic [49:0]          s4_q;
   logic [22:0]          n_e;
   logic                 s5_valid, s5_ready;
   logic [72:0]          s5_q;
   logic                 e_valid, e_ready;
   logic [3:0]           e_quo;
   logic [49:0]          e_side;
   logic [8:0]           e_bd;
   logic [13:0]          e_c;
   logic [3:0]           month_o;
   logic [4:0]           day_o;
   logic [13:0]          year_o;
   logic [49:0]          out_q;
   mjd2cal_pkg::tod_type out_tod;

   // Input clamp and Julian day number at noon.
   always_comb begin
      mjd_c = req_mjd_day;
      if (req_mjd_day < mjd2cal_pkg::MJD_LOW) begin
         mjd_c = mjd2cal_pkg::MJD_LOW;
      end else if (req_mjd_day > mjd2cal_pkg::MJD_HIGH) begin
         mjd_c = mjd2cal_pkg::MJD_HIGH;
      end
      ms_c = req_ms_of_day;
      if (req_ms_of_day > mjd2cal_pkg::MS_DAY_MAX) begin
         ms_c = mjd2cal_pkg::MS_DAY_MAX;
      end
      z0 = $unsigned(mjd_c) + mjd2cal_pkg::JDN_OFFSET;
   end

   assign req_stall = !in_ready;

   mjd2cal_slice #(.W(50)) u_s0 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .in_data   ({z0, ms_c}),
      .out_valid (s0_valid),
      .out_ready (s0_ready),
      .out_data  (s0_q)
   );

   // Time of day: hours first, then minutes and milliseconds from the remainder.
   mjd2cal_cdiv #(
      .NW (27),
      .D  (mjd2cal_pkg::MS_PER_HOUR),
      .QW (5),
      .SW (23)
   ) u_div_hour (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid),
      .in_ready  (s0_ready),
      .num       (s0_q[26:0]),
      .in_side   (s0_q[49:27]),
      .out_valid (t1_valid),
      .out_ready (t1_ready),
      .quo       (t1_quo),
      .rem       (t1_rem),
      .out_side  (t1_side)
   );

   mjd2cal_cdiv #(
      .NW (22),
      .D  (mjd2cal_pkg::MS_PER_MINUTE),
      .QW (6),
      .SW (28)
   ) u_div_minute (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t1_valid),
      .in_ready  (t1_ready),
      .num       (t1_rem),
      .in_side   ({t1_side, t1_quo}),
      .out_valid (t2_valid),
      .out_ready (t2_ready),
      .quo       (t2_quo),
      .rem       (t2_rem),
      .out_side  (t2_side)
   );

   always_comb begin
      t2_z             = t2_side[27:5];
      tod.hour         = t2_side[4:0];
      tod.minute       = t2_quo;
      tod.ms_of_minute = t2_rem;
      greg             = (t2_z >= mjd2cal_pkg::REFORM_JDN);
      n_alpha          = greg ? 24'({t2_z, 2'b00} - mjd2cal_pkg::ALPHA_BIAS) : 24'd0;
   end

   mjd2cal_slice #(.W(75)) u_s1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t2_valid),
      .in_ready  (t2_ready),
      .in_data   ({n_alpha, greg, t2_z, tod}),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_q)
   );

   // Gregorian century correction.
   mjd2cal_cdiv #(
      .NW (24),
      .D  (mjd2cal_pkg::DAYS_PER_400Y),
      .QW (7),
      .SW (51)
   ) u_div_alpha (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .num       (s1_q[74:51]),
      .in_side   (s1_q[50:0]),
      .out_valid (a_valid),
      .out_ready (a_ready),
      .quo       (a_quo),
      .rem       (),
      .out_side  (a_side)
   );

   always_comb begin
      a_adj = {1'b0, a_quo} - {3'b000, a_quo[6:2]} + 8'd1;
      if (!a_side[50]) begin
         a_adj = 8'd0;
      end
      b2 = a_side[49:27] + 23'(a_adj) + mjd2cal_pkg::B_OFFSET;
   end

   mjd2cal_slice #(.W(50)) u_s2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid),
      .in_ready  (a_ready),
      .in_data   ({b2, a_side[26:0]}),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_q)
   );

   assign n_c = {s2_q[49:27], 4'b0000} + 27'({s2_q[49:27], 2'b00}) - mjd2cal_pkg::C_BIAS;

   mjd2cal_slice #(.W(77)) u_s3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   ({n_c, s2_q}),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_q)
   );

   // Year term of the Meeus method.
   mjd2cal_cdiv #(
      .NW (27),
      .D  (mjd2cal_pkg::C_DIVISOR),
      .QW (14),
      .SW (50)
   ) u_div_year (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .num       (s3_q[76:50]),
      .in_side   (s3_q[49:0]),
      .out_valid (c_valid),
      .out_ready (c_ready),
      .quo       (c_quo),
      .rem       (),
      .out_side  (c_side)
   );

   // Days left in the year after whole years, counted from a March-based year.
   always_comb begin
      d_prod = 25'(c_quo) * mjd2cal_pkg::DAYS_PER_4Y;
      bd4    = 9'(c_side[49:27] - d_prod[24:2]);
   end

   mjd2cal_slice #(.W(50)) u_s4 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_ready  (c_ready),
      .in_data   ({bd4, c_quo, c_side[26:0]}),
      .out_valid (s4_valid),
      .out_ready (s4_ready),
      .out_data  (s4_q)
   );

   assign n_e = 23'(s4_q[49:41]) * mjd2cal_pkg::MONTH_SCALE;

   mjd2cal_slice #(.W(73)) u_s5 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid),
      .in_ready  (s4_ready),
      .in_data   ({n_e, s4_q}),
      .out_valid (s5_valid),
      .out_ready (s5_ready),
      .out_data  (s5_q)
   );

   // Month term of the Meeus method.
   mjd2cal_cdiv #(
      .NW (23),
      .D  (mjd2cal_pkg::MONTH_DIVISOR),
      .QW (4),
      .SW (50)
   ) u_div_month (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_valid),
      .in_ready  (s5_ready),
      .num       (s5_q[72:50]),
      .in_side   (s5_q[49:0]),
      .out_valid (e_valid),
      .out_ready (e_ready),
      .quo       (e_quo),
      .rem       (),
      .out_side  (e_side)
   );

   always_comb begin
      e_bd    = e_side[49:41];
      e_c     = e_side[40:27];
      month_o = (e_quo < mjd2cal_pkg::MONTH_WRAP) ? (e_quo - 4'd1) : (e_quo - 4'd13);
      day_o   = 5'(e_bd - mjd2cal_pkg::month_start(e_quo));
      year_o  = (month_o > mjd2cal_pkg::MONTH_FEBRUARY) ? (e_c - mjd2cal_pkg::YEAR_OFF_MARCH)
                                                        : (e_c - mjd2cal_pkg::YEAR_OFF_JANUARY);
   end

   mjd2cal_slice #(.W(50)) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid),
      .in_ready  (e_ready),
      .in_data   ({year_o, month_o, day_o, e_side[26:0]}),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (out_q)
   );

   assign out_tod          = out_q[26:0];
   assign rsp_year         = out_q[49:36];
   assign rsp_month        = out_q[35:32];
   assign rsp_day          = out_q[31:27];
   assign rsp_hour         = out_tod.hour;
   assign rsp_minute       = out_tod.minute;
   assign rsp_ms_of_minute = out_tod.ms_of_minute;

`ifndef SYNTH
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the result side is free");

   a_date_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1
                     && rsp_year >= 14'd1 && rsp_year <= 14'd9999))
      else $error("calendar date out of range");

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour <= 5'd23 && rsp_minute <= 6'd59
                     && rsp_ms_of_minute <= 16'd59999))
      else $error("time of day out of range");

   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result beat present right after reset");
`endif

endmodule
